[design/i2d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2d_pkg
// Shared types and constants of the integer to decimal text unit.
// ---------------------------------------------------------------------------
package i2d_pkg;

  localparam int unsigned ITER_W = 5;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic REG_WIDTH_SEL = 1'b0;
  localparam logic REG_IS_SIGNED = 1'b1;

  typedef struct packed {
    logic              neg;
    logic [ITER_W-1:0] iters;
  } i2d_ctrl_t;

endpackage
`default_nettype wire

[design/integer_to_decimal_text_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// integer_to_decimal_text_unit
// Converts an integer operand to its decimal ASCII text, one character per
// transaction, most significant first, with the final character marked.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid_i/in_stall_o raw_bits_i
//   output   out        out_valid_o/out_stall_i text_char_o, last_char_o
//   config   in         APB psel/penable      paddr, pwdata, prdata
//
// The time an operand takes is set by the four-bit-per-cycle shift-add-three
// conversion loop and the single character output register.
// Reset clears the queue, the sequencer and the output valid.
// A stalled output holds its character; the two-entry queue keeps taking
// operands until it is full.
// ---------------------------------------------------------------------------
module integer_to_decimal_text_unit import i2d_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [VALUE_BITS-1:0] raw_bits_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [7:0]            text_char_o,
  output logic                       last_char_o
);

  localparam int unsigned MAG_W  = ((VALUE_BITS + 3) / 4) * 4;
  localparam int unsigned DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned QW     = $bits(i2d_ctrl_t) + MAG_W;

  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  i2d_ctrl_t        push_ctrl;
  i2d_ctrl_t        pop_ctrl;
  logic [MAG_W-1:0] push_mag;
  logic [MAG_W-1:0] pop_mag;

  i2d_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAG_W     (MAG_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .raw_bits_i(raw_bits_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_ctrl_o  (push_ctrl),
    .q_mag_o   (push_mag)
  );

  i2d_queue #(
    .W(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i({push_ctrl, push_mag}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .rdata_o({pop_ctrl, pop_mag})
  );

  i2d_back #(
    .MAG_W (MAG_W),
    .DIGITS(DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .q_ctrl_i   (pop_ctrl),
    .q_mag_i    (pop_mag),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .text_char_o(text_char_o),
    .last_char_o(last_char_o)
  );

endmodule
`default_nettype wire

[design/i2d_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2d_front
// Holds the configuration registers, accepts operands, forms sign and
// magnitude and aligns the magnitude for the digit conversion.
// ---------------------------------------------------------------------------
module i2d_front import i2d_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned MAG_W      = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [VALUE_BITS-1:0] raw_bits_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output i2d_ctrl_t                  q_ctrl_o,
  output logic      [MAG_W-1:0]      q_mag_o
);

  localparam logic [6:0] VB  = 7'(VALUE_BITS);
  localparam logic [6:0] MW7 = 7'(MAG_W);

  logic [1:0]            width_sel_q;
  logic                  is_signed_q;
  logic                  wr_en;
  logic [6:0]            w_full;
  logic [6:0]            w_eff;
  logic [6:0]            w_pad;
  logic [6:0]            shamt;
  logic [VALUE_BITS-1:0] mask;
  logic [VALUE_BITS-1:0] x;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_sel_q <= 2'd3;
      is_signed_q <= 1'b1;
    end else if (wr_en) begin
      case (paddr[2])
        REG_WIDTH_SEL: width_sel_q <= pwdata[1:0];
        REG_IS_SIGNED: is_signed_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH_SEL: prdata = {30'd0, width_sel_q};
      REG_IS_SIGNED: prdata = {31'd0, is_signed_q};
      default:       prdata = 32'd0;
    endcase
  end

  always_comb begin
    w_full = 7'd8 << width_sel_q;
    w_eff  = (w_full > VB) ? VB : w_full;
    w_pad  = (w_eff + 7'd3) & 7'h7C;
    shamt  = MW7 - w_pad;
    mask   = {VALUE_BITS{1'b1}} >> (VB - w_eff);
    x      = raw_bits_i & mask;
    neg    = is_signed_q && ((x & (mask ^ (mask >> 1))) != '0);
    mag    = neg ? ((~x + VALUE_BITS'(1)) & mask) : x;
  end

  assign in_stall_o     = q_full_i;
  assign q_push_o       = in_valid_i && !q_full_i;
  assign q_ctrl_o.neg   = neg;
  assign q_ctrl_o.iters = ITER_W'(w_pad >> 2);
  assign q_mag_o        = MAG_W'(mag) << shamt;

endmodule
`default_nettype wire

[design/i2d_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2d_queue
// Two-entry queue between the operand front end and the digit back end.
// ---------------------------------------------------------------------------
module i2d_queue #(
  parameter int unsigned W = 70
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] wdata_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              empty_o,
  output logic      [W-1:0] rdata_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q;
  logic         rptr_q;
  logic [1:0]   count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

[design/i2d_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2d_back
// Converts a magnitude to packed decimal digits four bits per cycle, finds
// the leading digit and emits the characters through an output register.
// ---------------------------------------------------------------------------
module i2d_back import i2d_pkg::*; #(
  parameter int unsigned MAG_W  = 64,
  parameter int unsigned DIGITS = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  output logic                  q_pop_o,
  input  i2d_ctrl_t             q_ctrl_i,
  input  wire logic [MAG_W-1:0] q_mag_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [7:0]       text_char_o,
  output logic                  last_char_o
);

  localparam int unsigned BCD_W = DIGITS * 4;
  localparam int unsigned IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SIZE = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d, bcd_step;
  logic [MAG_W-1:0]  mag_q, mag_d, mag_step;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              neg_q, neg_d;
  logic [IDX_W-1:0]  idx_q, idx_d, idx_top;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        char_q, char_d;
  logic              last_q, last_d;
  logic              out_free;

  always_comb begin
    bcd_step = bcd_q;
    mag_step = mag_q;
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_step[d*4 +: 4] >= 4'd5) begin
          bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
        end
      end
      bcd_step = {bcd_step[BCD_W-2:0], mag_step[MAG_W-1]};
      mag_step = mag_step << 1;
    end
  end

  always_comb begin
    idx_top = '0;
    for (int d = 1; d < DIGITS; d++) begin
      if (bcd_q[d*4 +: 4] != 4'd0) begin
        idx_top = IDX_W'(d);
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    bcd_d       = bcd_q;
    mag_d       = mag_q;
    iter_d      = iter_q;
    neg_d       = neg_q;
    idx_d       = idx_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          bcd_d   = '0;
          mag_d   = q_mag_i;
          iter_d  = q_ctrl_i.iters;
          neg_d   = q_ctrl_i.neg;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        bcd_d  = bcd_step;
        mag_d  = mag_step;
        iter_d = iter_q - ITER_W'(1);
        if (iter_q == ITER_W'(1)) begin
          state_d = S_SIZE;
        end
      end
      S_SIZE: begin
        idx_d   = idx_top;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            char_d = CHAR_MINUS;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            char_d = CHAR_ZERO + {4'd0, bcd_q[{idx_q, 2'b00} +: 4]};
            last_d = (idx_q == '0);
            idx_d  = idx_q - IDX_W'(1);
            if (idx_q == '0) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    mag_q  <= mag_d;
    iter_q <= iter_d;
    neg_q  <= neg_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Checks the integer to decimal text unit against a predictor of the decimal
// characters each operand should produce. Directed extremes come first, then
// random operands under each width and signedness setting but 64-bit signed,
// with random idle bursts on both channels, one long output hold-off and a calm last phase of random format.
// ---------------------------------------------------------------------------
module tb;
  import i2d_pkg::*;

  localparam int unsigned VALUE_BITS = 64;

  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  localparam logic [2:0] ADDR_WIDTH_SEL = {REG_WIDTH_SEL, 2'b00};
  localparam logic [2:0] ADDR_IS_SIGNED = {REG_IS_SIGNED, 2'b00};

  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned HOLD_CYCLES   = 120;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  class decimal_text_checker;
    logic [1:0]  width_sel;
    logic        is_signed;
    text_item_t  expected_chars[$];
    int unsigned errors;

    function new();
      width_sel = WSEL_64;
      is_signed = 1'b1;
      errors    = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function int unsigned operand_bits();
      int unsigned w;
      w = 8 << width_sel;
      if (w > VALUE_BITS) w = VALUE_BITS;
      return w;
    endfunction

    function void note_operand(input logic [63:0] raw);
      int unsigned w;
      logic [63:0] mask, x, mag, rem;
      logic        neg;
      logic [7:0]  digits[$];
      text_item_t  item;
      w    = operand_bits();
      mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
      x    = raw & mask;
      neg  = is_signed && x[w-1];
      mag  = neg ? ((~x + 64'd1) & mask) : x;
      do begin
        rem = mag % 64'd10;
        digits.push_front(CHAR_ZERO + rem[7:0]);
        mag = mag / 64'd10;
      end while (mag != 64'd0);
      if (neg) begin
        item.ch   = CHAR_MINUS;
        item.last = 1'b0;
        expected_chars.push_back(item);
      end
      foreach (digits[i]) begin
        item.ch   = digits[i];
        item.last = (i == digits.size() - 1);
        expected_chars.push_back(item);
      end
    endfunction

    task check_char(input logic [7:0] ch, input logic last);
      text_item_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("character %h with nothing expected", ch));
      end else begin
        want = expected_chars.pop_front();
        if (ch !== want.ch)
          report_mismatch($sformatf("text_char %h, expected %h", ch, want.ch));
        if (last !== want.last)
          report_mismatch($sformatf("last_char %b, expected %b", last, want.last));
      end
    endtask

    function int unsigned outstanding();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] raw_bits_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  text_char_o;
  logic        last_char_o;

  logic calm     = 1'b0;
  logic hold_off = 1'b0;

  decimal_text_checker checker_h = new();

  integer_to_decimal_text_unit #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_bits_i  (raw_bits_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) checker_h.check_char(text_char_o, last_char_o);
  end

  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_format(input logic [1:0] wsel, input logic sgn);
    write_register(ADDR_WIDTH_SEL, (32'($urandom) & ~32'd3) | 32'(wsel));
    write_register(ADDR_IS_SIGNED, (32'($urandom) & ~32'd1) | 32'(sgn));
    checker_h.width_sel = wsel;
    checker_h.is_signed = sgn;
  endtask

  task automatic send_operand(input logic [63:0] raw);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_bits_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    checker_h.note_operand(raw);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (checker_h.outstanding() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [63:0] pick_operand(input int unsigned w);
    logic [63:0] v, mask, p;
    mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    case ($urandom_range(0, 9))
      0: v = 64'd0;
      1: v = '1;
      2: v = 64'd1 << (w - 1);
      3: v = (64'd1 << (w - 1)) - 64'd1;
      4: begin
        p = 64'd1;
        repeat ($urandom_range(1, 19)) p = p * 64'd10;
        v = p - 64'($urandom_range(0, 1));
      end
      5: v = 64'($urandom_range(0, 20));
      6: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: v = {$urandom, $urandom};
    endcase
    return (v & mask) | ({$urandom, $urandom} & ~mask);
  endfunction

  initial begin : stimulus
    logic [1:0] wsel;
    logic       sgn;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = 3'd0;
    pwdata     = 32'd0;
    in_valid_i = 1'b0;
    raw_bits_i = 64'd0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset format: 64-bit signed.
    send_operand(64'd0);
    send_operand(64'd1);
    send_operand(64'd9);
    send_operand(64'd10);
    send_operand(64'd99);
    send_operand(64'd100);
    send_operand('1);
    send_operand(64'h8000_0000_0000_0000);
    send_operand(64'h7FFF_FFFF_FFFF_FFFF);
    send_operand(64'hFFFF_FFFF_FFFF_FFF6);
    drain();

    set_format(WSEL_64, 1'b0);
    send_operand('1);
    send_operand(64'd10_000_000_000_000_000_000);
    send_operand(64'h8000_0000_0000_0000);
    drain();

    set_format(WSEL_8, 1'b1);
    send_operand(64'hA5A5_A5A5_A5A5_A580);
    send_operand(64'h5A5A_5A5A_5A5A_5A7F);
    send_operand(64'hFFFF_FFFF_FFFF_FFFF);
    send_operand(64'hFFFF_FFFF_FFFF_FF00);
    drain();

    set_format(WSEL_8, 1'b0);
    send_operand(64'h1234_5678_9ABC_DEFF);
    send_operand(64'hFFFF_FFFF_FFFF_FF00);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      wsel = phase[2:1];
      sgn  = phase[0];
      if (phase == 7) begin
        wsel = 2'($urandom_range(0, 3));
        sgn  = 1'($urandom_range(0, 1));
        calm = 1'b1;
      end
      set_format(wsel, sgn);
      if (phase == 2) hold_off = 1'b1;
      repeat (30) send_operand(pick_operand(checker_h.operand_bits()));
      drain();
    end

    if (checker_h.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
